// ----- rtl/bpa_pkg.sv -----
`default_nettype none
package bpa_pkg;

   localparam int PAGE_W            = 21;
   localparam int MAX_PAGES_DEF     = 65536;
   localparam int MAP_WORD_BITS_DEF = 64;
   localparam logic [7:0] RESET_FILL = 8'hFF;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [15:0] start_page;
      logic [16:0] page_count;
   } bpa_req_type;

   typedef struct packed {
      logic [15:0] first_page;
      logic        success;
      logic [16:0] pages_changed;
      logic [16:0] free_total;
   } bpa_rsp_type;

   typedef struct packed {
      logic              is_free;
      logic              skip;
      logic [PAGE_W-1:0] lo;
      logic [PAGE_W-1:0] hi;
      logic [PAGE_W-1:0] cnt;
      logic [PAGE_W-1:0] total;
   } bpa_cmd_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCAN,
      ST_SWEEP,
      ST_DONE
   } bpa_state_type;

endpackage
`default_nettype wire

// ----- rtl/bpa_front.sv -----
`default_nettype none
module bpa_front import bpa_pkg::*; #(
   parameter int MAX_PAGES = MAX_PAGES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire bpa_req_type req_data,
   input  wire logic        csr_we,
   input  wire logic [16:0] csr_wdata,
   input  wire logic        init_done,
   output logic             q_valid,
   output bpa_cmd_type      q_cmd,
   input  wire logic        q_take
);

   logic [16:0]       page_total_ff;
   logic [PAGE_W-1:0] total;
   logic [PAGE_W-1:0] end_pg;
   logic [PAGE_W-1:0] lo;
   logic [PAGE_W-1:0] hi;
   logic [PAGE_W-1:0] cnt;
   bpa_cmd_type       cmd;
   bpa_cmd_type       ent_ff [2];
   logic              wp_ff;
   logic              rp_ff;
   logic [1:0]        cnt_ff;
   logic              push;

   always_ff @(posedge clock) begin
      if (reset) begin
         page_total_ff <= '0;
      end else if (csr_we) begin
         page_total_ff <= csr_wdata;
      end
   end

   always_comb begin
      total  = (PAGE_W'(page_total_ff) > PAGE_W'(MAX_PAGES)) ? PAGE_W'(MAX_PAGES)
                                                             : PAGE_W'(page_total_ff);
      cnt    = PAGE_W'(req_data.page_count);
      end_pg = PAGE_W'(req_data.start_page) + cnt;
      lo     = (req_data.start_page == 16'd0) ? PAGE_W'(1) : PAGE_W'(req_data.start_page);
      hi     = (end_pg > total) ? total : end_pg;
      cmd.is_free = (req_data.req_type == REQ_FREE);
      cmd.lo      = lo;
      cmd.hi      = hi;
      cmd.cnt     = cnt;
      cmd.total   = total;
      if (req_data.req_type == REQ_FREE) begin
         cmd.skip = (lo >= hi);
      end else begin
         cmd.skip = (cnt == '0) || (cnt > total);
      end
   end

   assign req_ready = init_done && (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_cmd     = ent_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wp_ff] <= cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wp_ff <= ~wp_ff;
         end
         if (q_take) begin
            rp_ff <= ~rp_ff;
         end
         cnt_ff <= cnt_ff + 2'(push) - 2'(q_take);
      end
   end

endmodule
`default_nettype wire

// ----- rtl/bpa_back.sv -----
`default_nettype none
module bpa_back import bpa_pkg::*; #(
   parameter int MAX_PAGES     = MAX_PAGES_DEF,
   parameter int MAP_WORD_BITS = MAP_WORD_BITS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   output logic              init_done,
   input  wire logic         q_valid,
   input  wire bpa_cmd_type  q_cmd,
   output logic              q_take,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output bpa_rsp_type       rsp_data
);

   localparam int WB        = MAP_WORD_BITS;
   localparam int MAP_WORDS = (MAX_PAGES + WB - 1) / WB;
   localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BIW       = $clog2(WB);

   logic [WB-1:0]     mem [MAP_WORDS];
   logic [WB-1:0]     mem_q;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [WB-1:0]     wr_data;

   bpa_state_type     state_ff, state_in;
   bpa_cmd_type       cmd_ff, cmd_in;
   logic [AW-1:0]     cur_ff, cur_in;
   logic [PAGE_W-1:0] base_ff, base_in;
   logic [PAGE_W-1:0] run_len_ff, run_len_in;
   logic [PAGE_W-1:0] run_begin_ff, run_begin_in;
   logic [AW-1:0]     run_word_ff, run_word_in;
   logic [PAGE_W-1:0] run_base_ff, run_base_in;
   logic [PAGE_W-1:0] lo_ff, lo_in;
   logic [PAGE_W-1:0] hi_ff, hi_in;
   logic              set_ff, set_in;
   logic [PAGE_W-1:0] changed_ff, changed_in;
   logic              ok_ff, ok_in;
   logic [PAGE_W-1:0] start_ff, start_in;
   logic [PAGE_W-1:0] free_ff, free_in;
   logic [AW-1:0]     init_ff, init_in;
   logic              rsp_valid_ff, rsp_valid_in;
   bpa_rsp_type       rsp_ff, rsp_in;

   logic [WB-1:0]     used;
   logic [WB-1:0]     any_used;
   logic [BIW-1:0]    last_idx [WB];
   logic [PAGE_W-1:0] runlen [WB];
   logic [WB-1:0]     hit;
   logic              hit_any;
   logic [BIW-1:0]    hit_idx;
   logic [PAGE_W-1:0] carry_begin;
   logic [AW-1:0]     carry_word;
   logic [PAGE_W-1:0] carry_base;
   logic [WB-1:0]     mask;
   logic [WB-1:0]     swept;
   logic [PAGE_W-1:0] pop;
   logic [PAGE_W-1:0] pg;
   logic [PAGE_W-1:0] sw_pg;
   logic [PAGE_W-1:0] new_free;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_q <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // per-bit view of the current word for the first-fit search
   always_comb begin
      for (int i = 0; i < WB; i++) begin
         pg      = base_ff + PAGE_W'(i);
         used[i] = mem_q[i] || (pg == '0) || (pg >= cmd_ff.total);
      end
      for (int i = 0; i < WB; i++) begin
         any_used[i] = 1'b0;
         last_idx[i] = '0;
         for (int j = 0; j <= i; j++) begin
            if (used[j]) begin
               any_used[i] = 1'b1;
               last_idx[i] = BIW'(j);
            end
         end
      end
      for (int i = 0; i < WB; i++) begin
         if (used[i]) begin
            runlen[i] = '0;
         end else if (any_used[i]) begin
            runlen[i] = PAGE_W'(i) - PAGE_W'(last_idx[i]);
         end else begin
            runlen[i] = run_len_ff + PAGE_W'(i + 1);
         end
         hit[i] = !used[i] && (runlen[i] >= cmd_ff.cnt);
      end
      hit_any = |hit;
      hit_idx = '0;
      for (int i = WB - 1; i >= 0; i--) begin
         if (hit[i]) begin
            hit_idx = BIW'(i);
         end
      end
      carry_begin = (run_len_ff == '0) ? base_ff : run_begin_ff;
      carry_word  = (run_len_ff == '0) ? cur_ff : run_word_ff;
      carry_base  = (run_len_ff == '0) ? base_ff : run_base_ff;
   end

   // range mask and update of the current word for marking or releasing
   always_comb begin
      pop = '0;
      for (int i = 0; i < WB; i++) begin
         sw_pg   = base_ff + PAGE_W'(i);
         mask[i] = (sw_pg >= lo_ff) && (sw_pg < hi_ff);
         pop     = pop + PAGE_W'(mem_q[i] & mask[i]);
      end
      swept = set_ff ? (mem_q | mask) : (mem_q & ~mask);
   end

   always_comb begin
      if (cmd_ff.is_free) begin
         new_free = free_ff + changed_ff;
      end else if (ok_ff) begin
         new_free = free_ff - cmd_ff.cnt;
      end else begin
         new_free = free_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_ff      <= '0;
         free_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      cur_ff       <= cur_in;
      base_ff      <= base_in;
      run_len_ff   <= run_len_in;
      run_begin_ff <= run_begin_in;
      run_word_ff  <= run_word_in;
      run_base_ff  <= run_base_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      set_ff       <= set_in;
      changed_ff   <= changed_in;
      ok_ff        <= ok_in;
      start_ff     <= start_in;
      rsp_ff       <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      cur_in       = cur_ff;
      base_in      = base_ff;
      run_len_in   = run_len_ff;
      run_begin_in = run_begin_ff;
      run_word_in  = run_word_ff;
      run_base_in  = run_base_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      set_in       = set_ff;
      changed_in   = changed_ff;
      ok_in        = ok_ff;
      start_in     = start_ff;
      init_in      = init_ff;
      free_in      = free_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      q_take       = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = cur_ff;
      wr_data      = swept;
      case (state_ff)
         ST_INIT: begin
            wr_en   = 1'b1;
            wr_addr = init_ff;
            wr_data = {WB{RESET_FILL[0]}};
            init_in = init_ff + AW'(1);
            if (init_ff == AW'(MAP_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_take     = 1'b1;
               cmd_in     = q_cmd;
               changed_in = '0;
               ok_in      = q_cmd.is_free;
               start_in   = '0;
               cur_in     = '0;
               base_in    = '0;
               run_len_in = '0;
               if (q_cmd.skip) begin
                  state_in = ST_DONE;
               end else if (q_cmd.is_free) begin
                  lo_in    = q_cmd.lo;
                  hi_in    = q_cmd.hi;
                  set_in   = 1'b0;
                  rd_en    = 1'b1;
                  state_in = ST_SWEEP;
               end else begin
                  rd_en    = 1'b1;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (hit_any) begin
               if (any_used[hit_idx]) begin
                  start_in = base_ff + PAGE_W'(last_idx[hit_idx]) + PAGE_W'(1);
                  cur_in   = cur_ff;
                  base_in  = base_ff;
               end else begin
                  start_in = carry_begin;
                  cur_in   = carry_word;
                  base_in  = carry_base;
               end
               lo_in      = start_in;
               hi_in      = start_in + cmd_ff.cnt;
               set_in     = 1'b1;
               ok_in      = 1'b1;
               changed_in = cmd_ff.cnt;
               rd_en      = 1'b1;
               rd_addr    = cur_in;
               state_in   = ST_SWEEP;
            end else if ((base_ff + PAGE_W'(WB) >= cmd_ff.total) ||
                         (cur_ff == AW'(MAP_WORDS - 1))) begin
               state_in = ST_DONE;
            end else begin
               if (runlen[WB-1] == '0) begin
                  run_len_in = '0;
               end else if (any_used[WB-1]) begin
                  run_len_in   = runlen[WB-1];
                  run_begin_in = base_ff + PAGE_W'(last_idx[WB-1]) + PAGE_W'(1);
                  run_word_in  = cur_ff;
                  run_base_in  = base_ff;
               end else begin
                  run_len_in   = runlen[WB-1];
                  run_begin_in = carry_begin;
                  run_word_in  = carry_word;
                  run_base_in  = carry_base;
               end
               cur_in  = cur_ff + AW'(1);
               base_in = base_ff + PAGE_W'(WB);
               rd_en   = 1'b1;
               rd_addr = cur_in;
            end
         end
         ST_SWEEP: begin
            wr_en = 1'b1;
            if (!set_ff) begin
               changed_in = changed_ff + pop;
            end
            if (base_ff + PAGE_W'(WB) >= hi_ff) begin
               state_in = ST_DONE;
            end else begin
               cur_in  = cur_ff + AW'(1);
               base_in = base_ff + PAGE_W'(WB);
               rd_en   = 1'b1;
               rd_addr = cur_in;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_in.first_page    = 16'(start_ff);
               rsp_in.success       = ok_ff;
               rsp_in.pages_changed = 17'(changed_ff);
               rsp_in.free_total    = 17'(new_free);
               free_in              = new_free;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign init_done = (state_ff != ST_INIT);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> (rd_addr != wr_addr))
      else $error("read and write of the same map word");

   a_sweep_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (base_ff < hi_ff))
      else $error("sweep past end of range");

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= PAGE_W'(MAX_PAGES))
      else $error("free count above page limit");

   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      q_take |=> (state_ff != ST_IDLE))
      else $error("request taken without leaving idle");

endmodule
`default_nettype wire

// ----- rtl/bitmap_page_allocator.sv -----
// bitmap first-fit page allocator
// req channel: valid/ready, one request per handshake; req_type selects
//   allocate (run of page_count pages) or free (page_count pages from
//   start_page). rsp channel: valid/ready, exactly one response per request
//   in request order, held in an output register until taken.
// csr_we/csr_wdata write page_total; write it only while the block is idle.
// requests are classified and queued (two deep) ahead of the map engine.
// flow (engine idle): allocate scans one map word per cycle from page 1,
//   then marks the words of the first run that fits; free sweeps words
//   one per cycle from word 0 to the last word of the range, clearing
//   its bits. zero-length requests, allocates larger than the usable page
//   count and frees of an empty range skip the map and go to the response.
// throughput: one request at a time in the engine, set by the single
//   read and single write port of the map memory.
// reset: the map is filled with used marks by a pass that writes each
//   map word in turn, during which req_ready is low;
//   free count and page_total clear to zero.
// a stalled rsp_ready holds the response; the queue keeps taking requests
//   until it is full, then req_ready drops.
`default_nettype none
module bitmap_page_allocator import bpa_pkg::*; #(
   parameter int MAX_PAGES     = MAX_PAGES_DEF,
   parameter int MAP_WORD_BITS = MAP_WORD_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire bpa_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output bpa_rsp_type      rsp_data,
   input  wire logic        csr_we,
   input  wire logic [16:0] csr_wdata
);

   logic        init_done;
   logic        q_valid;
   bpa_cmd_type q_cmd;
   logic        q_take;

   bpa_front #(
      .MAX_PAGES (MAX_PAGES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .init_done (init_done),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_take    (q_take)
   );

   bpa_back #(
      .MAX_PAGES     (MAX_PAGES),
      .MAP_WORD_BITS (MAP_WORD_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .init_done (init_done),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_take    (q_take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
